// ----- rtl/stli_pkg.sv -----
// Package for the sorted-table linear interpolator: command and clamp codes,
// transfer structs, ALU status flags and the sequencer state type.
// No dependencies.
package stli_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 11;
  localparam int unsigned COUNT_W = 12;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } stli_cmd_e;

  typedef enum logic [1:0] {
    CLAMP_INTERIOR = 2'd0,
    CLAMP_BELOW    = 2'd1,
    CLAMP_ABOVE    = 2'd2,
    CLAMP_EMPTY    = 2'd3
  } stli_clamp_e;

  typedef struct packed {
    stli_cmd_e                  cmd;
    logic [INDEX_W-1:0]         entry_index;
    logic [DATA_W-1:0]          entry_radius;
    logic signed [DATA_W-1:0]   entry_value;
    logic [DATA_W-1:0]          query_radius;
  } stli_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   interp_value;
    stli_clamp_e                clamp_code;
  } stli_out_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } stli_flags_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_PROBE,
    ST_CMP,
    ST_GETA,
    ST_GETB,
    ST_RATIO,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_FIN
  } stli_state_e;

endpackage

// ----- rtl/sorted_table_linear_interpolator.sv -----
// Sorted-table linear interpolator. A write command (cmd = write) stores one
// radius/value entry; busy stays low. A query binary-searches the table for
// the first radius not below the query radius and interpolates between that
// entry and the one before it, clamping to the end values outside the table
// (empty table gives zero). For an interior point a query holds busy through
// its search probes on the single RAM read port, then through up to FRAC_BITS
// restoring-division steps and FRAC_BITS+1 shift-add multiply steps on the
// one shared adder. Clamped queries end at the first- or last-entry compare,
// an empty table at acceptance. Each result appears on result_o for one
// cycle with done_o high; the receiver cannot stall it, and a new start may
// be given in that same cycle. The user must see that entry_count is written
// through cfg_we_i/cfg_wdata_i only while busy is low; the block itself does
// not enforce this.
module sorted_table_linear_interpolator
  import stli_pkg::*;
#(
  parameter int TABLE_DEPTH = 2048,
  parameter int FRAC_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  stli_in_t            item_i,
  output logic                done_o,
  output stli_out_t           result_o,
  input  logic                cfg_we_i,
  input  logic [COUNT_W-1:0]  cfg_wdata_i
);

  localparam int AIW = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int AW  = FRAC_BITS + 34;
  localparam int TW  = FRAC_BITS + 1;
  localparam int CW  = $clog2(FRAC_BITS + 2);
  localparam int RW  = 2 * DATA_W;

  stli_state_e state_q, state_d;

  logic [COUNT_W-1:0]       entry_count_q;
  logic [DATA_W-1:0]        r_q, r_d;
  logic [NW-1:0]            n_q, n_d;
  logic [NW-1:0]            lo_q, lo_d;
  logic [NW-1:0]            hi_q, hi_d;
  logic [NW-1:0]            mid_q, mid_d;
  logic [DATA_W-1:0]        r0_q, r0_d;
  logic [DATA_W-1:0]        den_q, den_d;
  logic signed [DATA_W-1:0] v0_q, v0_d;
  logic signed [DATA_W-1:0] v1_q, v1_d;
  logic signed [DATA_W:0]   diff_q, diff_d;
  logic signed [AW-1:0]     work_q, work_d;
  logic [TW-1:0]            t_q, t_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic                     tzero_q, tzero_d;
  logic                     done_q, done_d;
  stli_out_t                result_q, result_d;

  logic                     ram_we;
  logic [AIW-1:0]           ram_waddr;
  logic [RW-1:0]            ram_wdata;
  logic                     ram_re;
  logic [AIW-1:0]           ram_raddr;
  logic [RW-1:0]            ram_rdata;
  logic [DATA_W-1:0]        rad_rd;
  logic signed [DATA_W-1:0] val_rd;

  logic signed [AW-1:0]     alu_a, alu_b, alu_y;
  logic                     alu_sub;
  stli_flags_t              alu_flags;

  logic                     accept;
  logic [31:0]              idx_ext;
  logic [31:0]              cnt_ext;
  logic [NW-1:0]            n_in;
  logic [NW-1:0]            last_idx;
  logic [NW-1:0]            mid_calc;
  logic [NW-1:0]            i_sel;
  logic [NW-1:0]            i_m1;
  logic [AW-32:0]           sat_top;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign idx_ext   = 32'(item_i.entry_index);
  assign cnt_ext   = 32'(entry_count_q);
  assign n_in      = (cnt_ext > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(entry_count_q);
  assign last_idx  = n_q - NW'(1);
  assign mid_calc  = lo_q + ((hi_q - lo_q) >> 1);
  assign rad_rd    = ram_rdata[RW-1:DATA_W];
  assign val_rd    = signed'(ram_rdata[DATA_W-1:0]);
  assign sat_top   = alu_y[AW-1:31];

  // Interpolation interval upper index, clamped to [1, n-1].
  always_comb begin
    i_sel = lo_q;
    if (i_sel == '0) begin
      i_sel = NW'(1);
    end
    if (i_sel > last_idx) begin
      i_sel = last_idx;
    end
    i_m1 = i_sel - NW'(1);
  end

  stli_ram #(
    .WIDTH (RW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stli_alu #(
    .WIDTH (AW)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .y_o     (alu_y),
    .flags_o (alu_flags)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && item_i.cmd == CMD_QUERY && n_in != '0) begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_d = (alu_flags.neg || alu_flags.zero) ? ST_IDLE : ST_LAST;
      end
      ST_LAST: begin
        state_d = !alu_flags.neg ? ST_IDLE : ST_PROBE;
      end
      ST_PROBE: begin
        state_d = (lo_q < hi_q) ? ST_CMP : ST_GETA;
      end
      ST_CMP:   state_d = ST_PROBE;
      ST_GETA:  state_d = ST_GETB;
      ST_GETB:  state_d = ST_RATIO;
      ST_RATIO: begin
        if (tzero_q || !alu_flags.neg) begin
          state_d = ST_DIFF;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_q == CW'(1)) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF:  state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == CW'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates
  always_comb begin
    r_d       = r_q;
    n_d       = n_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    r0_d      = r0_q;
    den_d     = den_q;
    v0_d      = v0_q;
    v1_d      = v1_q;
    diff_d    = diff_q;
    work_d    = work_q;
    t_d       = t_q;
    cnt_d     = cnt_q;
    tzero_d   = tzero_q;
    done_d    = 1'b0;
    result_d  = result_q;
    ram_we    = 1'b0;
    ram_waddr = idx_ext[AIW-1:0];
    ram_wdata = {item_i.entry_radius, item_i.entry_value};
    ram_re    = 1'b0;
    ram_raddr = '0;
    alu_a     = '0;
    alu_b     = '0;
    alu_sub   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (item_i.cmd == CMD_WRITE) begin
            ram_we = (idx_ext < 32'(TABLE_DEPTH));
          end else begin
            r_d = item_i.query_radius;
            n_d = n_in;
            if (n_in == '0) begin
              done_d                = 1'b1;
              result_d.interp_value = '0;
              result_d.clamp_code   = CLAMP_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
            end
          end
        end
      end
      ST_FIRST: begin
        alu_a = AW'(r_q);
        alu_b = AW'(rad_rd);
        if (alu_flags.neg || alu_flags.zero) begin
          done_d                = 1'b1;
          result_d.interp_value = val_rd;
          result_d.clamp_code   = CLAMP_BELOW;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = last_idx[AIW-1:0];
        end
      end
      ST_LAST: begin
        alu_a = AW'(r_q);
        alu_b = AW'(rad_rd);
        if (!alu_flags.neg) begin
          done_d                = 1'b1;
          result_d.interp_value = val_rd;
          result_d.clamp_code   = CLAMP_ABOVE;
        end else begin
          lo_d = '0;
          hi_d = n_q;
        end
      end
      ST_PROBE: begin
        ram_re = 1'b1;
        if (lo_q < hi_q) begin
          mid_d     = mid_calc;
          ram_raddr = mid_calc[AIW-1:0];
        end else begin
          mid_d     = i_sel;
          ram_raddr = i_m1[AIW-1:0];
        end
      end
      ST_CMP: begin
        // stored radius below query moves the lower bound past mid
        alu_a = AW'(rad_rd);
        alu_b = AW'(r_q);
        if (alu_flags.neg) begin
          lo_d = mid_q + NW'(1);
        end else begin
          hi_d = mid_q;
        end
      end
      ST_GETA: begin
        r0_d      = rad_rd;
        v0_d      = val_rd;
        alu_a     = AW'(r_q);
        alu_b     = AW'(rad_rd);
        work_d    = alu_y;
        tzero_d   = alu_flags.neg || alu_flags.zero;
        ram_re    = 1'b1;
        ram_raddr = mid_q[AIW-1:0];
      end
      ST_GETB: begin
        v1_d    = val_rd;
        alu_a   = AW'(rad_rd);
        alu_b   = AW'(r0_q);
        den_d   = alu_y[DATA_W-1:0];
        tzero_d = tzero_q || alu_flags.neg || alu_flags.zero;
      end
      ST_RATIO: begin
        alu_a = work_q;
        alu_b = AW'(den_q);
        cnt_d = CW'(FRAC_BITS);
        if (tzero_q) begin
          t_d = '0;
        end else if (!alu_flags.neg) begin
          t_d = TW'(1) << FRAC_BITS;
        end else begin
          t_d = '0;
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        alu_a  = work_q <<< 1;
        alu_b  = AW'(den_q);
        work_d = alu_flags.neg ? alu_a : alu_y;
        t_d    = {t_q[TW-2:0], !alu_flags.neg};
        cnt_d  = cnt_q - CW'(1);
      end
      ST_DIFF: begin
        alu_a  = AW'(v1_q);
        alu_b  = AW'(v0_q);
        diff_d = alu_y[DATA_W:0];
        work_d = '0;
        cnt_d  = CW'(TW);
      end
      ST_MUL: begin
        // shift-add multiply, fraction MSB first
        alu_sub = 1'b0;
        alu_a   = work_q <<< 1;
        alu_b   = t_q[TW-1] ? AW'(diff_q) : '0;
        work_d  = alu_y;
        t_d     = t_q << 1;
        cnt_d   = cnt_q - CW'(1);
      end
      ST_FIN: begin
        alu_sub = 1'b0;
        alu_a   = AW'(v0_q);
        alu_b   = work_q >>> FRAC_BITS;
        done_d  = 1'b1;
        result_d.clamp_code = CLAMP_INTERIOR;
        if ((&sat_top) || !(|sat_top)) begin
          result_d.interp_value = alu_y[DATA_W-1:0];
        end else if (alu_y[AW-1]) begin
          result_d.interp_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
          result_d.interp_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        entry_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    n_q      <= n_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    r0_q     <= r0_d;
    den_q    <= den_d;
    v0_q     <= v0_d;
    v1_q     <= v1_d;
    diff_q   <= diff_d;
    work_q   <= work_d;
    t_q      <= t_d;
    cnt_q    <= cnt_d;
    tzero_q  <= tzero_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // A result is only ever shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // Every accepted query either starts the search or answers at once.
  a_query_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == CMD_QUERY) |=> (busy || done_o))
    else $error("accepted query neither started nor answered");

  // Table writes never produce a result transfer.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == CMD_WRITE) |=> !done_o)
    else $error("write command produced a result");

endmodule

// ----- rtl/stli_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module stli_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stli_alu.sv -----
// Shared add/subtract unit used by the radius compares and the interpolation arithmetic.
// Depends on stli_pkg (status flag struct).
module stli_alu
  import stli_pkg::*;
#(
  parameter int WIDTH = 50
) (
  input  logic signed [WIDTH-1:0] a_i,
  input  logic signed [WIDTH-1:0] b_i,
  input  logic                    sub_i,
  output logic signed [WIDTH-1:0] y_o,
  output stli_flags_t             flags_o
);

  assign y_o          = sub_i ? (a_i - b_i) : (a_i + b_i);
  assign flags_o.neg  = y_o[WIDTH-1];
  assign flags_o.zero = (y_o == '0);

endmodule

// ----- dv/tb_sorted_table_linear_interpolator.sv -----
// Self-checking testbench for sorted_table_linear_interpolator: table writes,
// clamped and interior queries, predicted in-bench and compared per result.
// Depends on rtl/stli_pkg.sv and rtl/sorted_table_linear_interpolator.sv.
`timescale 1ns / 1ps

module tb_sorted_table_linear_interpolator;
  import stli_pkg::*;

  localparam int          DEPTH         = 2048;
  localparam int          FRAC          = 16;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  stli_in_t           item_drv    = '0;
  logic               done_o;
  stli_out_t          result_o;
  logic               cfg_we_i    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;

  // bench copy of the table and the count register
  logic [DATA_W-1:0]        rad_tab [DEPTH];
  logic signed [DATA_W-1:0] val_tab [DEPTH];
  int unsigned              active_count = 0;

  stli_out_t   interp_due [$];
  int unsigned mismatch_count = 0;
  int unsigned random_items   = 0;
  bit          gaps_on        = 1'b1;

  sorted_table_linear_interpolator #(
    .TABLE_DEPTH(DEPTH),
    .FRAC_BITS  (FRAC)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_drv),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #15ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic stli_out_t interp_lookup(input logic [DATA_W-1:0] r);
    stli_out_t         res;
    int unsigned       n, lo, hi, mid, k;
    longint unsigned   num, den;
    longint            va, vb, frac, acc;
    n = (active_count > DEPTH) ? DEPTH : active_count;
    res.interp_value = '0;
    res.clamp_code   = CLAMP_EMPTY;
    if (n == 0) return res;
    if (r <= rad_tab[0]) begin
      res.interp_value = val_tab[0];
      res.clamp_code   = CLAMP_BELOW;
      return res;
    end
    if (r >= rad_tab[n-1]) begin
      res.interp_value = val_tab[n-1];
      res.clamp_code   = CLAMP_ABOVE;
      return res;
    end
    // first entry whose radius is not below r
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (rad_tab[mid] < r) lo = mid + 1;
      else hi = mid;
    end
    k = (lo == 0) ? 1 : lo;
    if (k > n - 1) k = n - 1;
    va = longint'(val_tab[k-1]);
    vb = longint'(val_tab[k]);
    if (rad_tab[k] <= rad_tab[k-1] || r <= rad_tab[k-1]) begin
      frac = 0;
    end else begin
      num = longint'(r) - longint'(rad_tab[k-1]);
      den = longint'(rad_tab[k]) - longint'(rad_tab[k-1]);
      if (num >= den) frac = longint'(1) << FRAC;
      else frac = longint'((num << FRAC) / den);
    end
    // arithmetic shift of a signed product rounds toward minus infinity
    acc = va + ((frac * (vb - va)) >>> FRAC);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    res.interp_value = acc[DATA_W-1:0];
    res.clamp_code   = CLAMP_INTERIOR;
    return res;
  endfunction

  task automatic take_item(input stli_in_t it);
    if (it.cmd == CMD_WRITE) begin
      rad_tab[it.entry_index] = it.entry_radius;
      val_tab[it.entry_index] = it.entry_value;
    end else begin
      interp_due = {interp_due, interp_lookup(it.query_radius)};
    end
  endtask

  // Called at a rising edge; returns at the edge where the item transferred.
  task automatic send_item(input stli_in_t it);
    if (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 29);
    end
    start    <= 1'b1;
    item_drv <= it;
    do @(posedge clk_i); while (busy);
    take_item(it);
  endtask

  task automatic write_entry(input int unsigned idx, input logic [DATA_W-1:0] rad,
                             input logic [DATA_W-1:0] val);
    stli_in_t it;
    it.cmd          = CMD_WRITE;
    it.entry_index  = idx[INDEX_W-1:0];
    it.entry_radius = rad;
    it.entry_value  = val;
    it.query_radius = $urandom();
    send_item(it);
  endtask

  task automatic query_at(input logic [DATA_W-1:0] r);
    stli_in_t it;
    it.cmd          = CMD_QUERY;
    it.entry_index  = INDEX_W'($urandom_range(DEPTH - 1));
    it.entry_radius = $urandom();
    it.entry_value  = $urandom();
    it.query_radius = r;
    send_item(it);
  endtask

  task automatic wait_idle();
    int unsigned spent;
    spent = 0;
    start <= 1'b0;
    while ((interp_due.size() != 0 || busy) && spent < DRAIN_LIMIT) begin
      @(posedge clk_i);
      spent++;
    end
    if (interp_due.size() != 0) begin
      report_mismatch($sformatf("%0d query results never came", interp_due.size()));
      interp_due.delete();
    end
    // a trailing query may still be in flight with nothing left to check
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_entry_count(input int unsigned cnt);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cnt[COUNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    active_count  = cnt;
  endtask

  function automatic logic [DATA_W-1:0] pick_radius(input int unsigned n);
    int unsigned k;
    case ($urandom_range(9))
      0: return $urandom_range(rad_tab[0]);
      1: return $urandom_range(32'hFFFF_FFFF, rad_tab[n-1]);
      2: return rad_tab[$urandom_range(n - 1)];
      3: return $urandom();
      default: begin
        if (n < 2) return $urandom();
        k = $urandom_range(n - 1, 1);
        return $urandom_range(rad_tab[k], rad_tab[k-1]);
      end
    endcase
  endfunction

  // radii that only reach the entries loaded by test_count_past_depth
  function automatic logic [DATA_W-1:0] sparse_radius();
    case ($urandom_range(4))
      0: return $urandom_range(rad_tab[0]);
      1: return $urandom_range(32'hFFFF_FFFF, rad_tab[DEPTH-1]);
      2: return $urandom_range(rad_tab[1], rad_tab[0] + 1);
      3: return $urandom_range(rad_tab[2], rad_tab[1] + 1);
      default: return $urandom_range(rad_tab[DEPTH-1] - 1, rad_tab[DEPTH-2] + 1);
    endcase
  endfunction

  always @(posedge clk_i) begin : check_results
    stli_out_t want;
    if (rst_ni && done_o) begin
      if (interp_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: value %h code %0d",
                                  result_o.interp_value, result_o.clamp_code));
      end else begin
        want = interp_due.pop_front();
        if (result_o.interp_value !== want.interp_value)
          report_mismatch($sformatf("interp_value %h, predicted %h",
                                    result_o.interp_value, want.interp_value));
        if (result_o.clamp_code !== want.clamp_code)
          report_mismatch($sformatf("clamp_code %0d, predicted %0d",
                                    result_o.clamp_code, want.clamp_code));
      end
    end
  end

  // count is still at its reset value here
  task automatic test_empty_table();
    write_entry(DEPTH - 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    query_at(32'h0000_0000);
    query_at(32'hFFFF_FFFF);
    query_at($urandom());
  endtask

  task automatic test_single_entry();
    write_entry(0, 32'h8000_0000, 32'h8000_0000);
    set_entry_count(1);
    query_at(32'h0000_0000);
    query_at(32'h8000_0000);
    query_at(32'h8000_0001);
    query_at(32'hFFFF_FFFF);
  endtask

  // full radius span and a value swing from max to min positive/negative
  task automatic test_field_extremes();
    write_entry(0, 32'h0000_0000, 32'h7FFF_FFFF);
    write_entry(1, 32'h0001_0000, 32'h8000_0000);
    write_entry(2, 32'h0002_0000, 32'h0000_0000);
    write_entry(3, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    set_entry_count(4);
    query_at(32'h0000_0000);
    query_at(32'h0000_0001);
    query_at(32'h0001_8000);
    query_at(32'hFFFF_FFFE);
    query_at(32'hFFFF_FFFF);
  endtask

  task automatic test_unsorted_table();
    write_entry(0, 32'h0003_0000, 32'h0064_0000);
    write_entry(1, 32'h0001_0000, 32'hFF9C_0000);
    write_entry(2, 32'h0001_0000, 32'h0010_0000);
    write_entry(3, 32'h0005_0000, 32'h8000_0000);
    query_at(32'h0004_0000);
    query_at(32'h0004_8000);
    query_at(32'h0003_0001);
  endtask

  task automatic test_random_tables();
    logic [DATA_W-1:0] fresh_rad [200];
    logic [DATA_W-1:0] r;
    int unsigned       m, n, step, a, b, nq;
    bit                descending;
    while (random_items < RANDOM_ITEMS) begin
      // one long stretch with no idling on the input side
      gaps_on = (random_items < RANDOM_ITEMS / 2) ||
                (random_items >= 3 * RANDOM_ITEMS / 4);
      m    = ($urandom_range(7) == 0) ? $urandom_range(200, 17) : $urandom_range(16, 2);
      step = 32'hFFFF_FFFF / m;
      r    = $urandom_range(step - 1);
      for (int i = 0; i < m; i++) begin
        fresh_rad[i] = r;
        r += $urandom_range(step - 1, 1);
      end
      // some tables out of order
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(3, 1)) begin
          a = $urandom_range(m - 1);
          b = $urandom_range(m - 1);
          r = fresh_rad[a];
          fresh_rad[a] = fresh_rad[b];
          fresh_rad[b] = r;
        end
      end
      descending = 1'($urandom_range(1));
      for (int i = 0; i < m; i++) begin
        a = descending ? m - 1 - i : i;
        write_entry(a, fresh_rad[a], $urandom());
      end
      random_items += m;
      n = ($urandom_range(3) == 0) ? $urandom_range(m, 1) : m;
      set_entry_count(n);
      nq = $urandom_range(24, 6);
      repeat (nq) begin
        if ($urandom_range(9) == 0) begin
          a = $urandom_range(m - 1);
          write_entry(a, $urandom_range(1) ? rad_tab[a] : $urandom(), $urandom());
        end else begin
          query_at(pick_radius(n));
        end
        random_items++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // Counts at and past the depth, then zero. Only entry 0, the last entry and the
  // binary-search paths next to both ends are loaded; radii rise with the
  // index and leave a wide gap between neighbors.
  task automatic test_count_past_depth();
    int unsigned idx;
    gaps_on = 1'b0;
    write_entry(0, $urandom_range(32'h000F_FFFF), $urandom());
    for (int j = 0; j <= 10; j++) begin
      idx = 1 << j;
      write_entry(idx, (idx << 21) + $urandom_range(32'h000F_FFFF), $urandom());
    end
    for (int j = 2; j <= 11; j++) begin
      idx = DEPTH - (DEPTH >> j);
      write_entry(idx, (idx << 21) + $urandom_range(32'h000F_FFFF), $urandom());
    end
    set_entry_count(DEPTH);
    repeat (10) query_at(sparse_radius());
    set_entry_count(2 ** COUNT_W - 1);
    repeat (6) query_at(sparse_radius());
    set_entry_count(DEPTH + 1);
    repeat (6) query_at(sparse_radius());
    set_entry_count(0);
    repeat (3) query_at($urandom());
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_single_entry();
    test_field_extremes();
    test_unsorted_table();
    test_random_tables();
    test_count_past_depth();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sorted_table_linear_interpolator.f -----
rtl/stli_pkg.sv
rtl/stli_ram.sv
rtl/stli_alu.sv
rtl/sorted_table_linear_interpolator.sv
dv/tb_sorted_table_linear_interpolator.sv
